// File: src/hlca_pkg.sv
`default_nettype none
package hlca_pkg;

  localparam int LeafCount = 4096;
  localparam int IdxW = 12;
  localparam int CoordW = 17;
  localparam int CoordFrac = 16;
  localparam int CoeffFrac = 24;
  localparam int TermShift = 2 * CoordFrac + 3 - CoeffFrac;
  localparam int WideW = 20;
  localparam int MemW = 32 * 3 + 4;

  typedef struct packed {
    logic [IdxW-1:0]   leaf_index;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] coeff_horizontal;
    logic signed [31:0] coeff_vertical;
    logic signed [31:0] coeff_diagonal;
    logic [3:0]         boundary_mask;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_SPLIT, ST_DIV, ST_MID, ST_MULT, ST_ACC,
    ST_NEXT, ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic latch_rd;
    logic split;
    logic div_step;
    logic mid;
    logic mult;
    logic acc;
    logic next;
    logic wr;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic need_div;
    logic div_done;
    logic more;
    logic clr_done;
  } status_t;

endpackage
`default_nettype wire

// File: src/hlca_ram.sv
`default_nettype none
module hlca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/hlca_ctrl.sv
`default_nettype none
module hlca_ctrl import hlca_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  status_t      status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         done
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
        if (start) state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.latch_rd = 1'b1;
        state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (status.ready) state_next = ST_MULT;
        else if (status.need_div) state_next = ST_DIV;
        else state_next = ST_SPLIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_MID;
      end
      ST_MID: begin
        cmd.mid = 1'b1;
        state_next = ST_SPLIT;
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.next = 1'b1;
        state_next = status.more ? ST_SPLIT : ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/hlca_dp.sv
`default_nettype none
module hlca_dp import hlca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t out_item
);
  // pieces kept as a small work list: pending segment records
  typedef struct packed {
    logic signed [WideW-1:0] x0, y0, x1, y1;
    logic [1:0] lvl;   // 0 needs x split, 1 needs y split, 2 ready
    logic qi, qj;
  } seg_rec_t;

  localparam logic signed [WideW-1:0] One = WideW'(1 << CoordFrac);

  seg_rec_t   stk [3];
  logic [1:0] sp;
  logic [IdxW-1:0] idx, clr_idx;
  logic clr_last;
  logic signed [31:0] acc_h, acc_v, acc_d;
  logic [3:0] bmask;
  logic sat;
  logic [MemW-1:0] rdata;

  seg_rec_t top;
  logic dir, s_lo, e_lo;
  logic signed [WideW-1:0] p0d, p1d, p0o, p1o;
  assign top = stk[sp - 2'd1];
  assign dir = top.lvl[0];
  assign p0d = dir ? top.y0 : top.x0;
  assign p1d = dir ? top.y1 : top.x1;
  assign p0o = dir ? top.x0 : top.y0;
  assign p1o = dir ? top.x1 : top.y1;
  assign s_lo = p0d < One;
  assign e_lo = p1d < One;

  // restoring divider: quotient of |num|<<F by |den|, one integer bit then F fraction bits
  localparam int QW = CoordFrac + 1;
  localparam int MW = WideW + QW + 2;
  logic [WideW:0] rem;
  logic [WideW-1:0] dvs;
  logic [QW-1:0] quo;
  logic [4:0] dcnt;
  logic [WideW+1:0] trial;
  logic div_last;
  assign trial = {1'b0, rem} - {2'b0, dvs};
  assign div_last = cmd.div_step && dcnt == '0;

  // midpoint product register
  logic signed [MW-1:0] mprod;
  logic signed [QW:0] tq;
  logic signed [WideW:0] dlt;
  assign tq = (dvs == '0 || quo > QW'(One)) ? $signed({1'b0, QW'(One >>> 1)})
                                              : $signed({1'b0, quo});
  assign dlt = {p1o[WideW-1], p1o} - {p0o[WideW-1], p0o};

  // term products
  logic signed [2*WideW+1:0] ph, pv;
  logic signed [WideW:0] lx, ly, dy, dx;
  always_comb begin
    lx = {top.x0[WideW-1], top.x0} + {top.x1[WideW-1], top.x1};
    ly = {top.y0[WideW-1], top.y0} + {top.y1[WideW-1], top.y1};
    if (top.qi) lx = {One, 1'b0} - lx;
    if (top.qj) ly = {One, 1'b0} - ly;
    dy = {top.y1[WideW-1], top.y1} - {top.y0[WideW-1], top.y0};
    dx = {top.x0[WideW-1], top.x0} - {top.x1[WideW-1], top.x1};
  end

  function automatic logic signed [2*WideW+1:0] rnd(input logic signed [2*WideW+1:0] v);
    logic [2*WideW+1:0] mag;
    mag = v[2*WideW+1] ? -v : v;
    mag = (mag + (2*WideW+2)'(1 << (TermShift-1))) >> TermShift;
    return v[2*WideW+1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [32:0] sadd(input logic signed [31:0] a,
                                       input logic signed [2*WideW+1:0] t);
    logic signed [2*WideW+2:0] r;
    r = {{(2*WideW-29){a[31]}}, a} + {t[2*WideW+1], t};
    if (r > 32'sh7fffffff) return {1'b1, 32'h7fffffff};
    if (r < -(2*WideW+3)'(64'sh80000000)) return {1'b1, 32'h80000000};
    return {1'b0, r[31:0]};
  endfunction

  logic signed [2*WideW+1:0] th, tv;
  assign th = rnd(ph);
  assign tv = rnd(pv);
  logic [32:0] nh, nv, nd;
  assign nh = sadd(acc_h, th);
  assign nv = sadd(acc_v, tv);
  assign nd = sadd(acc_d, top.qj ? -th : th);

  // memory: h, v, d, mask packed
  logic we;
  logic [IdxW-1:0] waddr;
  logic [MemW-1:0] wdata;
  assign we = cmd.wr | cmd.clr_wr;
  assign waddr = cmd.clr_wr ? clr_idx : idx;
  assign wdata = cmd.clr_wr ? '0 : {acc_h, acc_v, acc_d, bmask};

  hlca_ram #(.Width(MemW), .Depth(LeafCount)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr(idx), .rdata
  );

  assign clr_last = clr_idx == IdxW'(LeafCount - 1);

  logic signed [WideW-1:0] m_other;
  always_comb begin
    logic [MW-1:0] mg;
    logic signed [MW-1:0] rs;
    mg = mprod[MW-1] ? -mprod : mprod;
    mg = (mg + MW'(1 << (CoordFrac-1))) >> CoordFrac;
    rs = mprod[MW-1] ? -$signed(mg) : $signed(mg);
    m_other = p0o + rs[WideW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      sp <= '0;
    end else begin
      if (cmd.clr_wr && !clr_last) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        idx <= in_item.leaf_index;
        sat <= 1'b0;
        sp <= 2'd1;
        if ((in_item.x_start >= CoordW'(One >>> 1)) == (in_item.x_end >= CoordW'(One >>> 1)) &&
            (in_item.y_start >= CoordW'(One >>> 1)) == (in_item.y_end >= CoordW'(One >>> 1)))
        begin
          stk[0].qi <= in_item.x_start >= CoordW'(One >>> 1);
          stk[0].qj <= in_item.y_start >= CoordW'(One >>> 1);
          stk[0].x0 <= {2'b0, in_item.x_start, 1'b0}
                       - ((in_item.x_start >= CoordW'(One >>> 1)) ? One : '0);
          stk[0].y0 <= {2'b0, in_item.y_start, 1'b0}
                       - ((in_item.y_start >= CoordW'(One >>> 1)) ? One : '0);
          stk[0].x1 <= {2'b0, in_item.x_end, 1'b0}
                       - ((in_item.x_start >= CoordW'(One >>> 1)) ? One : '0);
          stk[0].y1 <= {2'b0, in_item.y_end, 1'b0}
                       - ((in_item.y_start >= CoordW'(One >>> 1)) ? One : '0);
          stk[0].lvl <= 2'd2;
        end else begin
          stk[0].qi <= 1'b0;
          stk[0].qj <= 1'b0;
          stk[0].x0 <= {2'b0, in_item.x_start, 1'b0};
          stk[0].y0 <= {2'b0, in_item.y_start, 1'b0};
          stk[0].x1 <= {2'b0, in_item.x_end, 1'b0};
          stk[0].y1 <= {2'b0, in_item.y_end, 1'b0};
          stk[0].lvl <= 2'd0;
        end
      end
      if (cmd.latch_rd) begin
        {acc_h, acc_v, acc_d, bmask} <= rdata;
      end
      if (cmd.split && top.lvl != 2'd2) begin
        if (s_lo == e_lo) begin
          // whole segment on one side
          stk[sp-2'd1].lvl <= top.lvl + 2'd1;
          if (!s_lo) begin
            if (dir) begin
              stk[sp-2'd1].qj <= 1'b1;
              stk[sp-2'd1].y0 <= top.y0 - One;
              stk[sp-2'd1].y1 <= top.y1 - One;
            end else begin
              stk[sp-2'd1].qi <= 1'b1;
              stk[sp-2'd1].x0 <= top.x0 - One;
              stk[sp-2'd1].x1 <= top.x1 - One;
            end
          end
        end else begin
          rem <= {1'b0, (One > p0d) ? One - p0d : p0d - One};
          dvs <= (p1d > p0d) ? p1d - p0d : p0d - p1d;
          quo <= '0;
          dcnt <= 5'(QW);
        end
      end
      if (cmd.div_step && dcnt != '0) begin
        // compare, subtract, then shift the partial remainder up
        dcnt <= dcnt - 1'b1;
        if (!trial[WideW+1]) begin
          rem <= {trial[WideW-1:0], 1'b0};
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= {rem[WideW-1:0], 1'b0};
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      // midpoint product once the quotient is final
      if (div_last) mprod <= dlt * tq;
      if (cmd.mid) begin
        // two children: low side piece and high side piece
        seg_rec_t lo_s, hi_s;
        logic signed [WideW-1:0] mx, my;
        lo_s = top;
        hi_s = top;
        mx = dir ? m_other : One;
        my = dir ? One : m_other;
        if (s_lo) begin
          lo_s.x1 = mx; lo_s.y1 = my;
          hi_s.x0 = mx; hi_s.y0 = my;
        end else begin
          hi_s.x1 = mx; hi_s.y1 = my;
          lo_s.x0 = mx; lo_s.y0 = my;
        end
        if (dir) begin
          hi_s.y0 = hi_s.y0 - One; hi_s.y1 = hi_s.y1 - One; hi_s.qj = 1'b1;
        end else begin
          hi_s.x0 = hi_s.x0 - One; hi_s.x1 = hi_s.x1 - One; hi_s.qi = 1'b1;
        end
        lo_s.lvl = top.lvl + 2'd1;
        hi_s.lvl = top.lvl + 2'd1;
        // process low first: push high below
        stk[sp-2'd1] <= hi_s;
        stk[sp] <= lo_s;
        sp <= sp + 2'd1;
      end
      if (cmd.mult) begin
        ph <= lx * dy;
        pv <= ly * dx;
      end
      if (cmd.acc) begin
        acc_h <= nh[31:0];
        acc_v <= nv[31:0];
        acc_d <= nd[31:0];
        bmask <= bmask | (4'b1 << {top.qj, top.qi});
        sat <= sat | nh[32] | nv[32] | nd[32];
      end
      if (cmd.next) sp <= sp - 2'd1;
    end
  end

  // x-level pieces push y-level children; order matches the model:
  // quadrant i=0 first (low x), then j=0 before j=1
  assign status.ready = top.lvl == 2'd2;
  assign status.need_div = top.lvl != 2'd2 && s_lo != e_lo;
  assign status.div_done = div_last;
  assign status.more = sp != 2'd1;
  assign status.clr_done = clr_last;

  assign out_item.coeff_horizontal = acc_h;
  assign out_item.coeff_vertical = acc_v;
  assign out_item.coeff_diagonal = acc_d;
  assign out_item.boundary_mask = bmask;
  assign out_item.saturated = sat;
endmodule
`default_nettype wire

// File: src/haar_line_coeff_accumulator_core.sv
`default_nettype none
// sequence: a segment inside one quadrant is read, latched, split, multiplied,
// accumulated and written back; a segment needs up to three clip divides
// (17 quotient steps plus a product step each); one item at a time, busy until done,
// with the pace set by the serial divider and the entry update
// reset: synchronous; after reset a clearing pass zeroes all 4096 entries of the
// coefficient memory while busy stays high
// results cannot be stalled: done pulses one cycle with the updated entry
module haar_line_coeff_accumulator_core import hlca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      done,
  output out_item_t out_item
);
  cmd_t    cmd;
  status_t status;

  // controller walks the segment pieces
  hlca_ctrl u_ctrl (.clk, .rst, .start, .status, .cmd, .busy, .done);

  // datapath holds piece list, divider, multipliers and the entry memory
  hlca_dp u_dp (.clk, .rst, .in_item, .cmd, .status, .out_item);

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy");
  a_start_acc: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after accept");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("not idle after done");
`endif
endmodule
`default_nettype wire

// File: test/haar_line_coeff_accumulator_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module haar_line_coeff_accumulator_core_tb;
  import hlca_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  initial begin
    forever #2 clk = ~clk;
  end

  // block ports
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      done;
  out_item_t out_item;

  haar_line_coeff_accumulator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  localparam longint One = 64'sd1 << CoordFrac;
  localparam int WatchLimit = 20000;

  // predicted leaf entries, mirrored from the block's store
  int   horiz_acc [LeafCount];
  int   vert_acc  [LeafCount];
  int   diag_acc  [LeafCount];
  logic [3:0] quad_flags [LeafCount];

  out_item_t entry_q[$];
  int  mismatches = 0;
  int  beats_sent = 0;
  int  beats_seen = 0;
  int  saturated_seen = 0;
  int  idle_cycles = 0;
  bit  sender_idles = 1'b1;

  // per-segment working copy: [point][axis]
  typedef longint seg_pts_t [2][2];

  // scale by 2^-s with round half away from zero
  function automatic longint rnd_shift(longint v, int s);
    longint mag;
    if (s <= 0) return v <<< (-s);
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic int clip_add(int acc, longint term, ref bit sat);
    longint r;
    r = longint'(acc) + term;
    if (r > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (r < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(r);
  endfunction

  // cut a segment at the line axis==One into a low and a high piece
  function automatic void clip_at_one(input seg_pts_t p, output seg_pts_t lo,
                                      output seg_pts_t hi, output bit has_lo,
                                      output bit has_hi, input int axis);
    int oth;
    bit s_lo, e_lo;
    longint num, den, t;
    longint mid [2];
    oth = 1 - axis;
    s_lo = p[0][axis] < One;
    e_lo = p[1][axis] < One;
    lo = p;
    hi = p;
    if (s_lo && e_lo) begin
      has_lo = 1; has_hi = 0;
      return;
    end
    if (!s_lo && !e_lo) begin
      has_lo = 0; has_hi = 1;
      hi[0][axis] -= One; hi[1][axis] -= One;
      return;
    end
    num = One - p[0][axis];
    den = p[1][axis] - p[0][axis];
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    if (den == 0) t = One / 2;
    else begin
      t = (num <<< CoordFrac) / den;
      if (t > One) t = One / 2;
    end
    mid[oth] = p[0][oth] + rnd_shift((p[1][oth] - p[0][oth]) * t, CoordFrac);
    mid[axis] = One;
    has_lo = 1; has_hi = 1;
    if (s_lo) begin
      lo[1][0] = mid[0]; lo[1][1] = mid[1];
      hi[0][0] = mid[0]; hi[0][1] = mid[1];
    end else begin
      hi[1][0] = mid[0]; hi[1][1] = mid[1];
      lo[0][0] = mid[0]; lo[0][1] = mid[1];
    end
    hi[0][axis] -= One; hi[1][axis] -= One;
  endfunction

  // add one quadrant piece's haar detail terms to a leaf entry
  function automatic void add_quadrant(int idx, seg_pts_t s, int qi, int qj, ref bit sat);
    longint lx, ly, dy, dx, th, tv;
    lx = s[0][0] + s[1][0];
    ly = s[0][1] + s[1][1];
    dy = s[1][1] - s[0][1];
    dx = s[0][0] - s[1][0];
    if (qi != 0) lx = 2 * One - lx;
    if (qj != 0) ly = 2 * One - ly;
    th = rnd_shift(lx * dy, TermShift);
    tv = rnd_shift(ly * dx, TermShift);
    horiz_acc[idx] = clip_add(horiz_acc[idx], th, sat);
    diag_acc[idx]  = clip_add(diag_acc[idx], (qj != 0) ? -th : th, sat);
    vert_acc[idx]  = clip_add(vert_acc[idx], tv, sat);
    quad_flags[idx] |= 4'(1 << (qi + 2 * qj));
  endfunction

  // updated leaf entry that one segment beat produces
  function automatic out_item_t predict_entry(in_item_t it);
    int idx, qi, qj, ni, nj;
    bit sat;
    seg_pts_t p;
    seg_pts_t xs [2];
    seg_pts_t ys [4];
    bit xin [2];
    bit yin [4];
    out_item_t r;
    idx = int'(it.leaf_index) % LeafCount;
    sat = 0;
    p[0][0] = it.x_start; p[0][1] = it.y_start;
    p[1][0] = it.x_end;   p[1][1] = it.y_end;
    qi = p[0][0] >= One / 2; qj = p[0][1] >= One / 2;
    ni = p[1][0] >= One / 2; nj = p[1][1] >= One / 2;
    if (qi == ni && qj == nj) begin
      // both ends in one quadrant: map straight into it
      for (int q = 0; q < 2; q++) begin
        p[q][0] = p[q][0] * 2 - (qi != 0 ? One : 0);
        p[q][1] = p[q][1] * 2 - (qj != 0 ? One : 0);
      end
      add_quadrant(idx, p, qi, qj, sat);
    end else begin
      for (int q = 0; q < 2; q++) begin
        p[q][0] *= 2; p[q][1] *= 2;
      end
      xin = '{0, 0};
      yin = '{0, 0, 0, 0};
      clip_at_one(p, xs[0], xs[1], xin[0], xin[1], 0);
      for (int a = 0; a < 2; a++) begin
        if (xin[a]) begin
          clip_at_one(xs[a], ys[a], ys[a + 2], yin[a], yin[a + 2], 1);
          for (int b = 0; b < 2; b++)
            if (yin[a + 2 * b]) add_quadrant(idx, ys[a + 2 * b], a, b, sat);
        end
      end
    end
    r.coeff_horizontal = horiz_acc[idx];
    r.coeff_vertical   = vert_acc[idx];
    r.coeff_diagonal   = diag_acc[idx];
    r.boundary_mask    = quad_flags[idx];
    r.saturated        = sat;
    return r;
  endfunction

  // send one segment beat, predicting its entry at acceptance
  task automatic send_segment(logic [11:0] leaf, logic [16:0] xs, logic [16:0] ys,
                              logic [16:0] xe, logic [16:0] ye);
    in_item_t it;
    it = '{leaf, xs, ys, xe, ye};
    if (sender_idles && $urandom_range(99) < 19) begin
      start <= 1'b0;
      in_item <= in_item_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
      while (sender_idles && $urandom_range(99) < 19) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    entry_q.push_back(predict_entry(it));
    beats_sent++;
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(9))
      0: return 17'h10000;
      1: return 17'h1ffff - 17'($urandom_range(15));
      2: return 17'h08000 + 17'($urandom_range(4)) - 17'd2;
      3: return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // result checker: a done strobe is one beat, never stalled
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      beats_seen++;
      if (out_item.saturated) saturated_seen++;
      if (entry_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item);
      end else begin
        want = entry_q.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on beat %0d: expected %p, got %p", beats_seen, want, out_item);
        end
      end
    end
  end

  // watchdog: cycles in which no beat moves either way
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // corners, the quadrant lines and zero-length segments
  task automatic test_directed();
    send_segment(12'd0, 17'd0, 17'd0, 17'd0, 17'd0);
    send_segment(12'd0, 17'd100, 17'd200, 17'd30000, 17'd20000);
    send_segment(12'd1, 17'd0, 17'd0, 17'h10000, 17'h10000);
    send_segment(12'd1, 17'h10000, 17'd0, 17'd0, 17'h10000);
    send_segment(12'd2, 17'h7fff, 17'h7fff, 17'h8000, 17'h8000);
    send_segment(12'd2, 17'h8000, 17'd0, 17'h8000, 17'h10000);
    send_segment(12'd3, 17'd0, 17'h8000, 17'h10000, 17'h8000);
    send_segment(12'd3, 17'h10000, 17'd5, 17'd5, 17'h9000);
    send_segment(12'd4095, 17'h1ffff, 17'h1ffff, 17'd0, 17'd0);
    send_segment(12'd4095, 17'd0, 17'h1ffff, 17'h1ffff, 17'd0);
    send_segment(12'd4094, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff);
    send_segment(12'd4094, 17'h12345, 17'h0abcd, 17'h0abcd, 17'h12345);
    send_segment(12'd5, 17'd1, 17'h10000, 17'h10000, 17'd1);
    send_segment(12'd5, 17'h9000, 17'h9000, 17'h10000, 17'h10000);
  endtask

  // hammer two leaves with long diagonals, aiming to make the accumulators clip
  task automatic test_saturation();
    for (int k = 0; k < 60; k++) begin
      send_segment(12'd7, 17'd0, 17'h1ffff, 17'h1ffff, 17'd0);
      send_segment(12'd9, 17'h1ffff, 17'd0, 17'd0, 17'h1ffff);
    end
  endtask

  // random segments, mostly over a small leaf pool so entries keep accumulating
  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      sender_idles = !(k >= count / 3 && k < count / 2);
      send_segment(($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15)),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    foreach (horiz_acc[k]) begin
      horiz_acc[k] = 0; vert_acc[k] = 0; diag_acc[k] = 0; quad_flags[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random(420);
    start <= 1'b0;
    // drain: wait until every predicted entry has been checked
    while (entry_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d segment beats, %0d result beats, %0d of them clipped",
             beats_sent, beats_seen, saturated_seen);
    if (mismatches == 0 && entry_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
